@@ design/gql_pkg.sv @@
// Shared types and constants for the glyph quad layout block.
package gql_pkg;

	localparam int POS_W = 20;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_SIZE   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ADV  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_ADV   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_H    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_GAP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_V   = 3'd4;

	localparam logic [11:0] RST_SPACE_ADV = 12'd48;
	localparam logic [11:0] RST_LINE_ADV  = 12'd256;
	localparam logic [11:0] RST_GLYPH_H   = 12'd256;
	localparam logic [11:0] RST_GLYPH_GAP = 12'd16;
	localparam logic [15:0] RST_BOTTOM_V  = 16'd53248;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_FIRST   = 8'd32;
	localparam logic [7:0] CH_LAST    = 8'd127;

	// vertex slot of the final word of an item
	localparam logic [2:0] VTX_LAST = 3'd5;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_SPACE,
		CLS_NEWLINE,
		CLS_GLYPH,
		CLS_BAD,
		CLS_END
	} cls_t;

	typedef struct packed {
		logic [15:0] left_u;
		logic [15:0] right_u;
		logic [9:0]  width;
	} glyph_entry_t;

	typedef struct packed {
		logic [11:0] space_advance;
		logic [11:0] line_advance;
		logic [11:0] glyph_height;
		logic [11:0] glyph_gap;
		logic [15:0] bottom_v;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [1:0]       kind;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [15:0]      tex_u;
		logic [15:0]      tex_v;
		logic             last;
	} out_word_t;

endpackage

@@ design/gql_table.sv @@
// Glyph table memory: one write port, one registered read port.
module gql_table #(
	parameter int DEPTH = 96,
	parameter int IW = 7
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IW-1:0]         waddr,
	input  gql_pkg::glyph_entry_t wdata,
	input  logic                  re,
	input  logic [IW-1:0]         raddr,
	output gql_pkg::glyph_entry_t rdata
);

	gql_pkg::glyph_entry_t mem [DEPTH];
	gql_pkg::glyph_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/gql_emit.sv @@
// Pen state, vertex generation and output word sequencer.
module gql_emit #(
	parameter int POSITION_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  gql_pkg::cls_t         item_cls,
	input  gql_pkg::glyph_entry_t entry,
	input  gql_pkg::cfg_t         cfg,
	input  logic                  out_stall,
	output logic                  take,
	output gql_pkg::out_word_t    word
);

	localparam int P = POSITION_BITS;
	localparam int SW = POSITION_BITS + 2;
	localparam int PW = gql_pkg::POS_W;

	function automatic logic signed [P-1:0] sat(input logic signed [SW-1:0] v);
		logic all1;
		logic any1;
		all1 = &v[SW-1:P-1];
		any1 = |v[SW-1:P-1];
		if (all1 || !any1) begin
			return v[P-1:0];
		end else if (v[SW-1]) begin
			return {1'b1, {(P-1){1'b0}}};
		end else begin
			return {1'b0, {(P-1){1'b1}}};
		end
	endfunction

	function automatic logic [PW-1:0] to_port(input logic signed [P-1:0] v);
		return PW'(v);
	endfunction

	logic                busy_q;
	logic [2:0]          cnt_q;
	logic [1:0]          kind_q;
	logic signed [P-1:0] pen_x_q, pen_y_q, wide_q;
	logic signed [P-1:0] xl_q, xr_q, yt_q, yb_q;
	logic [15:0]         ul_q, ur_q, vb_q;

	logic                free;
	logic                emits;
	logic signed [SW-1:0] px_w, py_w, w_w, gap_w, sp_w, la_w, gh_w;
	logic signed [P-1:0] xr_n, yb_n, adv_n, sp_n, nl_y_n, wmax;

	assign free  = !busy_q || (!out_stall && cnt_q == gql_pkg::VTX_LAST);
	assign take  = item_valid && free;
	assign emits = (item_cls == gql_pkg::CLS_GLYPH) || (item_cls == gql_pkg::CLS_BAD) ||
		(item_cls == gql_pkg::CLS_END);

	always_comb begin
		px_w   = SW'(pen_x_q);
		py_w   = SW'(pen_y_q);
		w_w    = SW'($signed({1'b0, entry.width}));
		gap_w  = SW'($signed({1'b0, cfg.glyph_gap}));
		sp_w   = SW'($signed({1'b0, cfg.space_advance}));
		la_w   = SW'($signed({1'b0, cfg.line_advance}));
		gh_w   = SW'($signed({1'b0, cfg.glyph_height}));
		xr_n   = sat(px_w + w_w);
		adv_n  = sat(px_w + w_w + gap_w);
		yb_n   = sat(py_w - gh_w);
		sp_n   = sat(px_w + sp_w);
		nl_y_n = sat(py_w - la_w);
		wmax   = (pen_x_q > wide_q) ? pen_x_q : wide_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			pen_x_q <= '0;
			pen_y_q <= '0;
			wide_q  <= '0;
		end else begin
			if (take && emits) begin
				busy_q <= 1'b1;
			end else if (busy_q && !out_stall && cnt_q == gql_pkg::VTX_LAST) begin
				busy_q <= 1'b0;
			end
			if (busy_q && !out_stall && cnt_q != gql_pkg::VTX_LAST) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (take) begin
				case (item_cls)
					gql_pkg::CLS_SPACE: begin
						pen_x_q <= sp_n;
					end
					gql_pkg::CLS_NEWLINE: begin
						wide_q  <= wmax;
						pen_x_q <= '0;
						pen_y_q <= nl_y_n;
					end
					gql_pkg::CLS_GLYPH: begin
						cnt_q   <= '0;
						pen_x_q <= adv_n;
					end
					gql_pkg::CLS_BAD: begin
						cnt_q  <= gql_pkg::VTX_LAST;
					end
					gql_pkg::CLS_END: begin
						cnt_q   <= gql_pkg::VTX_LAST;
						pen_x_q <= '0;
						pen_y_q <= '0;
						wide_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (item_cls)
				gql_pkg::CLS_GLYPH: begin
					kind_q <= gql_pkg::KIND_VERTEX;
					xl_q   <= pen_x_q;
					xr_q   <= xr_n;
					yt_q   <= pen_y_q;
					yb_q   <= yb_n;
					ul_q   <= entry.left_u;
					ur_q   <= entry.right_u;
					vb_q   <= cfg.bottom_v;
				end
				gql_pkg::CLS_END: begin
					kind_q <= gql_pkg::KIND_SIZE;
					xr_q   <= wmax;
					yb_q   <= nl_y_n;
					ur_q   <= '0;
					vb_q   <= '0;
				end
				default: begin
					kind_q <= gql_pkg::KIND_ERROR;
					xr_q   <= '0;
					yb_q   <= '0;
					ur_q   <= '0;
					vb_q   <= '0;
				end
			endcase
		end
	end

	// vertex order: TL, BR, BL, TL, TR, BR
	always_comb begin
		word.valid = busy_q;
		word.kind  = kind_q;
		word.last  = (cnt_q == gql_pkg::VTX_LAST);
		case (cnt_q)
			3'd0, 3'd3: begin
				word.pos_x = to_port(xl_q);
				word.pos_y = to_port(yt_q);
				word.tex_u = ul_q;
				word.tex_v = '0;
			end
			3'd2: begin
				word.pos_x = to_port(xl_q);
				word.pos_y = to_port(yb_q);
				word.tex_u = ul_q;
				word.tex_v = vb_q;
			end
			3'd4: begin
				word.pos_x = to_port(xr_q);
				word.pos_y = to_port(yt_q);
				word.tex_u = ur_q;
				word.tex_v = '0;
			end
			default: begin
				word.pos_x = to_port(xr_q);
				word.pos_y = to_port(yb_q);
				word.tex_u = ur_q;
				word.tex_v = vb_q;
			end
		endcase
	end

endmodule

@@ design/glyph_quad_layout.sv @@
// Glyph quad layout top level: input decode, glyph table, config registers.
// An input word is registered with its table read, then loaded into the emitter registers.
// Throughput: a printable character yields six vertex words (one vertex word per cycle
// on the output port while out_stall is low); end and error words yield one word each.
// Reset (arst_n low): pen, widest line and handshake state clear, registers
// return to defaults; the glyph table keeps its contents and is not cleared.
module glyph_quad_layout #(
	parameter int GLYPH_COUNT = 96,
	parameter int POSITION_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [7:0]                        char_code,
	input  logic [15:0]                       glyph_left_u,
	input  logic [15:0]                       glyph_right_u,
	input  logic [9:0]                        glyph_width,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind,
	output logic signed [gql_pkg::POS_W-1:0]  pos_x,
	output logic signed [gql_pkg::POS_W-1:0]  pos_y,
	output logic [15:0]                       tex_u,
	output logic [15:0]                       tex_v,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [gql_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gql_pkg::CFG_W-1:0]         cfg_data
);

	localparam int IW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

	gql_pkg::cfg_t         cfg_q;
	gql_pkg::cls_t         cls_s0, cls_s1;
	gql_pkg::glyph_entry_t wentry, rentry;
	gql_pkg::out_word_t    word;
	logic                  s1_valid_q;
	logic                  accept, take;
	logic [7:0]            offset;
	logic                  in_table;
	logic [IW-1:0]         idx;

	assign accept   = in_valid && !in_stall;
	assign in_stall = s1_valid_q && !take;

	assign offset   = char_code - gql_pkg::CH_FIRST;
	assign in_table = (char_code >= gql_pkg::CH_FIRST) &&
		({1'b0, offset} < 9'(GLYPH_COUNT));
	assign idx      = offset[IW-1:0];
	assign wentry   = '{left_u: glyph_left_u, right_u: glyph_right_u, width: glyph_width};

	always_comb begin
		cls_s0 = gql_pkg::CLS_NONE;
		if (opcode == gql_pkg::OP_CHAR) begin
			if (char_code == gql_pkg::CH_SPACE) begin
				cls_s0 = gql_pkg::CLS_SPACE;
			end else if (char_code == gql_pkg::CH_NEWLINE) begin
				cls_s0 = gql_pkg::CLS_NEWLINE;
			end else if (in_table && char_code <= gql_pkg::CH_LAST) begin
				cls_s0 = gql_pkg::CLS_GLYPH;
			end else begin
				cls_s0 = gql_pkg::CLS_BAD;
			end
		end else if (opcode == gql_pkg::OP_END) begin
			cls_s0 = gql_pkg::CLS_END;
		end
	end

	gql_table #(
		.DEPTH(GLYPH_COUNT),
		.IW(IW)
	) u_table (
		.clk(clk),
		.we(accept && opcode == gql_pkg::OP_LOAD && in_table),
		.waddr(idx),
		.wdata(wentry),
		.re(accept && cls_s0 == gql_pkg::CLS_GLYPH),
		.raddr(idx),
		.rdata(rentry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_s0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.space_advance <= gql_pkg::RST_SPACE_ADV;
			cfg_q.line_advance  <= gql_pkg::RST_LINE_ADV;
			cfg_q.glyph_height  <= gql_pkg::RST_GLYPH_H;
			cfg_q.glyph_gap     <= gql_pkg::RST_GLYPH_GAP;
			cfg_q.bottom_v      <= gql_pkg::RST_BOTTOM_V;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gql_pkg::CFG_SPACE_ADV: cfg_q.space_advance <= cfg_data[11:0];
				gql_pkg::CFG_LINE_ADV:  cfg_q.line_advance  <= cfg_data[11:0];
				gql_pkg::CFG_GLYPH_H:   cfg_q.glyph_height  <= cfg_data[11:0];
				gql_pkg::CFG_GLYPH_GAP: cfg_q.glyph_gap     <= cfg_data[11:0];
				gql_pkg::CFG_BOTTOM_V:  cfg_q.bottom_v      <= cfg_data;
				default: ;
			endcase
		end
	end

	gql_emit #(
		.POSITION_BITS(POSITION_BITS)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(s1_valid_q),
		.item_cls(cls_s1),
		.entry(rentry),
		.cfg(cfg_q),
		.out_stall(out_stall),
		.take(take),
		.word(word)
	);

	assign out_valid = word.valid;
	assign kind      = word.kind;
	assign pos_x     = word.pos_x;
	assign pos_y     = word.pos_y;
	assign tex_u     = word.tex_u;
	assign tex_v     = word.tex_v;
	assign last      = word.last;

endmodule

@@ design/gql_check.sv @@
// Port-level checks on the glyph quad layout output stream, with bind.
module gql_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  kind,
	input logic [gql_pkg::POS_W-1:0]   pos_x,
	input logic [gql_pkg::POS_W-1:0]   pos_y,
	input logic [15:0]                 tex_u,
	input logic [15:0]                 tex_v,
	input logic                        last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(pos_x) &&
			$stable(pos_y) && $stable(tex_u) && $stable(tex_v) && $stable(last))
		else $error("stalled output word changed");

	a_quad_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind == gql_pkg::KIND_VERTEX && !last
			|=> out_valid && kind == gql_pkg::KIND_VERTEX)
		else $error("vertex group broken");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != gql_pkg::KIND_VERTEX |-> last)
		else $error("report or error word without last");

	a_no_tex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != gql_pkg::KIND_VERTEX |-> tex_u == 16'd0 && tex_v == 16'd0)
		else $error("report or error word with texture data");

endmodule

bind glyph_quad_layout gql_check u_gql_check (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind(kind),
	.pos_x(pos_x),
	.pos_y(pos_y),
	.tex_u(tex_u),
	.tex_v(tex_v),
	.last(last)
);

@@ tb/glyph_quad_layout_checker.sv @@
// Checker for glyph_quad_layout: predicts the vertex, size and error words and compares them.
`timescale 1ns / 100ps

module glyph_quad_layout_checker
	import gql_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [1:0]              opcode,
	input  logic [7:0]              char_code,
	input  logic [15:0]             glyph_left_u,
	input  logic [15:0]             glyph_right_u,
	input  logic [9:0]              glyph_width,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [1:0]              kind,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [15:0]             tex_u,
	input  logic [15:0]             tex_v,
	input  logic                    last,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      mismatches,
	output int                      outstanding
);

	localparam longint POS_MAX = (longint'(1) <<< (POS_W - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;

	typedef struct packed {
		logic [1:0]       kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [15:0]      u;
		logic [15:0]      v;
		logic             fin;
	} layout_word_t;

	cfg_t         regs;
	longint       pen_x;
	longint       pen_y;
	longint       widest_line;
	glyph_entry_t glyphs [0:95];
	layout_word_t pending_words [$];

	function automatic longint clamp_pos(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	function automatic layout_word_t make_word(input logic [1:0] k, input longint x,
			input longint y, input logic [15:0] u, input logic [15:0] v, input logic fin);
		layout_word_t w;
		w.kind = k;
		w.x = x[POS_W-1:0];
		w.y = y[POS_W-1:0];
		w.u = u;
		w.v = v;
		w.fin = fin;
		return w;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
			CFG_SPACE_ADV: regs.space_advance = data[11:0];
			CFG_LINE_ADV:  regs.line_advance = data[11:0];
			CFG_GLYPH_H:   regs.glyph_height = data[11:0];
			CFG_GLYPH_GAP: regs.glyph_gap = data[11:0];
			CFG_BOTTOM_V:  regs.bottom_v = data[15:0];
			default: ;
		endcase
	endtask

	task automatic predict_layout(input logic [1:0] op, input logic [7:0] code,
			input logic [15:0] lu, input logic [15:0] ru, input logic [9:0] w);
		longint       xl, xr, yt, yb, wd, h;
		glyph_entry_t g;
		logic         in_tbl;
		in_tbl = code >= CH_FIRST && code <= CH_LAST;
		case (op)
			OP_LOAD: begin
				if (in_tbl)
					glyphs[code - CH_FIRST] = {lu, ru, w};
			end
			OP_CHAR: begin
				if (code == CH_SPACE) begin
					pen_x = clamp_pos(pen_x + longint'(regs.space_advance));
				end else if (code == CH_NEWLINE) begin
					if (pen_x > widest_line)
						widest_line = pen_x;
					pen_x = 0;
					pen_y = clamp_pos(pen_y - longint'(regs.line_advance));
				end else if (!in_tbl) begin
					pending_words.push_back(make_word(KIND_ERROR, 0, 0, 16'd0, 16'd0, 1'b1));
				end else begin
					g = glyphs[code - CH_FIRST];
					xl = pen_x;
					xr = clamp_pos(pen_x + longint'(g.width));
					yt = pen_y;
					yb = clamp_pos(pen_y - longint'(regs.glyph_height));
					// two triangles: TL BR BL, TL TR BR
					pending_words.push_back(make_word(KIND_VERTEX, xl, yt, g.left_u, 16'd0, 1'b0));
					pending_words.push_back(make_word(KIND_VERTEX, xr, yb, g.right_u, regs.bottom_v,
						1'b0));
					pending_words.push_back(make_word(KIND_VERTEX, xl, yb, g.left_u, regs.bottom_v,
						1'b0));
					pending_words.push_back(make_word(KIND_VERTEX, xl, yt, g.left_u, 16'd0, 1'b0));
					pending_words.push_back(make_word(KIND_VERTEX, xr, yt, g.right_u, 16'd0, 1'b0));
					pending_words.push_back(make_word(KIND_VERTEX, xr, yb, g.right_u, regs.bottom_v,
						1'b1));
					pen_x = clamp_pos(pen_x + longint'(g.width) + longint'(regs.glyph_gap));
				end
			end
			OP_END: begin
				wd = widest_line;
				if (pen_x > wd)
					wd = pen_x;
				h = clamp_pos(pen_y - longint'(regs.line_advance));
				pending_words.push_back(make_word(KIND_SIZE, wd, h, 16'd0, 16'd0, 1'b1));
				pen_x = 0;
				pen_y = 0;
				widest_line = 0;
			end
			default: ;
		endcase
	endtask

	task automatic check_word();
		layout_word_t got;
		layout_word_t exp_w;
		got = {kind, pos_x, pos_y, tex_u, tex_v, last};
		if (pending_words.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: unexpected word kind %0d x %0d y %0d u %h v %h last %b", $realtime,
					got.kind, $signed(got.x), $signed(got.y), got.u, got.v, got.fin);
			mismatches <= mismatches + 1;
		end else begin
			exp_w = pending_words.pop_front();
			if (got !== exp_w) begin
				if (mismatches < 10) begin
					$write("%0t: word mismatch, expected kind %0d x %0d y %0d u %h v %h last %b,",
						$realtime, exp_w.kind, $signed(exp_w.x), $signed(exp_w.y), exp_w.u,
						exp_w.v, exp_w.fin);
					$display(" got kind %0d x %0d y %0d u %h v %h last %b",
						got.kind, $signed(got.x), $signed(got.y), got.u, got.v, got.fin);
				end
				mismatches <= mismatches + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = {RST_SPACE_ADV, RST_LINE_ADV, RST_GLYPH_H, RST_GLYPH_GAP, RST_BOTTOM_V};
			pen_x = 0;
			pen_y = 0;
			widest_line = 0;
			pending_words.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_word();
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				predict_layout(opcode, char_code, glyph_left_u, glyph_right_u, glyph_width);
			outstanding <= pending_words.size();
		end
	end

endmodule

@@ tb/glyph_quad_layout_test.sv @@
// Testbench top for glyph_quad_layout: clock, reset, text stimulus, config phases and verdict.
`timescale 1ns / 100ps

module glyph_quad_layout_test;
	import gql_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic [1:0]              opcode = OP_LOAD;
	logic [7:0]              char_code = '0;
	logic [15:0]             glyph_left_u = '0;
	logic [15:0]             glyph_right_u = '0;
	logic [9:0]              glyph_width = '0;
	logic                    out_stall = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_SPACE_ADV;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_stall;
	logic                    out_valid;
	logic [1:0]              kind;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [15:0]             tex_u;
	logic [15:0]             tex_v;
	logic                    last;
	int                      mismatches;
	int                      outstanding;
	bit                      steady = 1'b0;

	glyph_quad_layout uut (.*);

	glyph_quad_layout_checker layout_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 18);
	end

	task automatic send_word(input logic [1:0] op, input logic [7:0] code,
			input logic [15:0] lu, input logic [15:0] ru, input logic [9:0] w);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		char_code <= code;
		glyph_left_u <= lu;
		glyph_right_u <= ru;
		glyph_width <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_char(input logic [7:0] code);
		send_word(OP_CHAR, code, 16'($urandom), 16'($urandom), 10'($urandom));
	endtask

	task automatic send_end();
		send_word(OP_END, 8'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic set_cfg(input logic [15:0] sa, input logic [15:0] la, input logic [15:0] gh,
			input logic [15:0] gg, input logic [15:0] bv);
		drain();
		write_reg(CFG_SPACE_ADV, sa);
		write_reg(CFG_LINE_ADV, la);
		write_reg(CFG_GLYPH_H, gh);
		write_reg(CFG_GLYPH_GAP, gg);
		write_reg(CFG_BOTTOM_V, bv);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_text(input int count);
		int         n;
		int         r;
		logic [7:0] code;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				code = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(127, 32));
				send_word(OP_LOAD, code, 16'($urandom), 16'($urandom), 10'($urandom));
			end else if (r < 60) begin
				send_char(8'($urandom_range(127, 33)));
			end else if (r < 72) begin
				send_char(CH_SPACE);
			end else if (r < 80) begin
				send_char(CH_NEWLINE);
			end else if (r < 87) begin
				code = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255, 128));
				if (code == CH_NEWLINE)
					code = 8'd0;
				send_char(code);
			end else if (r < 95) begin
				send_end();
			end else begin
				send_word(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
			end
		end
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the whole table first so no character reads an empty entry
		for (i = 32; i < 128; i++)
			send_word(OP_LOAD, 8'(i), 16'($urandom), 16'($urandom), 10'($urandom));

		send_word(OP_LOAD, 8'd33, 16'h0000, 16'hFFFF, 10'd1023);
		send_word(OP_LOAD, CH_LAST, 16'hFFFF, 16'h0000, 10'd0);
		send_word(OP_LOAD, 8'd31, 16'h1234, 16'h5678, 10'd77);
		send_word(OP_LOAD, 8'd128, 16'hAAAA, 16'h5555, 10'd511);
		send_word(OP_LOAD, 8'd255, 16'hFFFF, 16'hFFFF, 10'd1023);
		send_word(OP_LOAD, 8'd0, 16'h0000, 16'h0000, 10'd0);
		send_char(8'd33);
		send_char(CH_LAST);
		send_char(CH_SPACE);
		send_char(8'd33);
		send_char(CH_NEWLINE);
		send_char(CH_LAST);
		send_char(8'd0);
		send_char(8'd9);
		send_char(8'd31);
		send_char(8'd128);
		send_char(8'd255);
		send_word(OP_UNUSED, 8'd33, 16'hFFFF, 16'hFFFF, 10'd1023);
		send_end();
		send_end();

		set_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_char(8'd33);
		send_char(CH_SPACE);
		send_char(CH_NEWLINE);
		send_char(8'd33);
		send_end();

		// full-scale settings, then drive the pen into both saturation limits
		set_cfg(16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'hFFFF);
		steady = 1'b1;
		for (i = 0; i < 130; i++)
			send_char(CH_SPACE);
		send_char(8'd33);
		send_char(CH_NEWLINE);
		for (i = 0; i < 130; i++)
			send_char(CH_NEWLINE);
		send_char(8'd33);
		send_end();
		random_text(25);
		steady = 1'b0;
		random_text(10);

		set_cfg(16'($urandom_range(4095)), 16'($urandom_range(4095)), 16'($urandom_range(4095)),
			16'($urandom_range(4095)), 16'($urandom));
		random_text(20);

		set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_text(15);

		set_cfg(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		random_text(10);

		set_cfg(16'(RST_SPACE_ADV), 16'(RST_LINE_ADV), 16'(RST_GLYPH_H), 16'(RST_GLYPH_GAP),
			RST_BOTTOM_V);
		random_text(15);

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("glyph_quad_layout_test passed");
		else
			$display("glyph_quad_layout_test failed");
		$finish;
	end

	initial begin
		#400000;
		$display("glyph_quad_layout_test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/gql_pkg.sv
design/gql_table.sv
design/gql_emit.sv
design/glyph_quad_layout.sv
design/gql_check.sv
tb/glyph_quad_layout_checker.sv
tb/glyph_quad_layout_test.sv
